>>> rtl/aes128_block_decrypt_core_defines.svh
// ----------------------------------------------------------------------------
// AES-128 decrypt core assertion macros
// Shared concurrent assertion helpers for the decrypt core.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_DECRYPT_CORE_DEFINES_SVH
`define AES128_BLOCK_DECRYPT_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define AES_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define AES_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/aesd_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 decrypt package
// Byte tables, GF(2^8) helpers and round-step functions.
// ----------------------------------------------------------------------------
package aesd_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int BLOCK_W    = 128;
  localparam int HALF_W     = 64;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;

  typedef logic [127:0] block_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int n = 0; n < 4; n++) begin
      if (b[n]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  // byte i of a block sits at bits 127-8i downto 120-8i (column-major, c*4+r)
  function automatic logic [7:0] get_b(input block_t s, input int i);
    return s[BLOCK_W-1-8*i -: 8];
  endfunction

  // one forward key-schedule step; rcon given per round
  function automatic block_t key_step(input block_t k, input logic [7:0] rcon);
    block_t n;
    logic [31:0] w [4];
    logic [31:0] t;
    for (int c = 0; c < 4; c++) w[c] = k[127-32*c -: 32];
    t = {sbox(w[3][23:16]) ^ rcon, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    n = {w[0], w[1], w[2], w[3]};
    return n;
  endfunction

  function automatic block_t inv_shift_sub(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[BLOCK_W-1-8*(c*4+r) -: 8] = inv_sbox(get_b(s, ((c - r) & 3) * 4 + r));
    return t;
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, c*4);
      a1 = get_b(s, c*4+1);
      a2 = get_b(s, c*4+2);
      a3 = get_b(s, c*4+3);
      t[BLOCK_W-1-8*(c*4)   -: 8] = gmul(a0,4'he)^gmul(a1,4'hb)^gmul(a2,4'hd)^gmul(a3,4'h9);
      t[BLOCK_W-1-8*(c*4+1) -: 8] = gmul(a0,4'h9)^gmul(a1,4'he)^gmul(a2,4'hb)^gmul(a3,4'hd);
      t[BLOCK_W-1-8*(c*4+2) -: 8] = gmul(a0,4'hd)^gmul(a1,4'h9)^gmul(a2,4'he)^gmul(a3,4'hb);
      t[BLOCK_W-1-8*(c*4+3) -: 8] = gmul(a0,4'hb)^gmul(a1,4'hd)^gmul(a2,4'h9)^gmul(a3,4'he);
    end
    return t;
  endfunction

  function automatic logic [7:0] rcon_of(input int r);
    logic [7:0] v;
    v = 8'h01;
    for (int i = 1; i < r; i++) v = xtime(v);
    return v;
  endfunction

endpackage

>>> rtl/aes128_block_decrypt_core.sv
// ----------------------------------------------------------------------------
// AES-128 block decrypt core
// Fully unrolled inverse cipher, one register stage per round.
// ----------------------------------------------------------------------------
//  channel | group             | content
//  in      | s_axis_t*         | tdata[63:0] cipher_high, tdata[127:64] cipher_low
//  out     | m_axis_t*         | tdata[63:0] plain_high, tdata[127:64] plain_low
//  cfg     | APB p*            | key_high @0x0, key_low @0x8
//
// One word per cycle while m_axis is ready and the round keys have settled; key add stage + ten round stages.
// Round keys come from a chain of ten registered key-schedule steps, so after
// reset or a key write the input is held off while they settle.
// Keys are to be written only while the core is idle; the core does not enforce this.
// Reset clears the key registers and all stage valid bits.
// A stall on m_axis freezes the whole pipe; nothing is dropped.
module aes128_block_decrypt_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // [63:0] cipher_high, [127:64] cipher_low
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // [63:0] plain_high, [127:64] plain_low
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import aesd_pkg::*;
  `include "aes128_block_decrypt_core_defines.svh"

  logic [63:0] key_high, key_low;
  block_t      rk [NUM_ROUNDS+1];
  block_t      rk_next [NUM_ROUNDS+1];
  block_t      st [NUM_ROUNDS+1];
  logic        vld [NUM_ROUNDS+1];
  logic        adv;
  logic        wr_en;
  logic [3:0]  key_wait;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (wr_en && paddr[2:0] == 3'd0) begin
      case ({1'b0, paddr[3]})
        REG_KEY_HIGH: key_high <= pwdata;
        REG_KEY_LOW:  key_low  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      4'h0:    prdata = key_high;
      4'h8:    prdata = key_low;
      default: prdata = '0;
    endcase
  end

  // round key chain: one registered step per round
  always_comb begin
    rk_next[0] = {key_high, key_low};
    for (int r = 1; r <= NUM_ROUNDS; r++)
      rk_next[r] = key_step(rk[r-1], rcon_of(r));
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r <= NUM_ROUNDS; r++) rk[r] <= rk_next[r];
  end

  // cycles left until the last round key reflects the key registers
  always_ff @(posedge clk) begin
    if (rst || wr_en) begin
      key_wait <= 4'(NUM_ROUNDS + 1);
    end else if (key_wait != 4'd0) begin
      key_wait <= key_wait - 4'd1;
    end
  end

  assign adv           = !vld[NUM_ROUNDS] || m_axis_tready;
  assign s_axis_tready = adv && (key_wait == 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NUM_ROUNDS; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_axis_tvalid && s_axis_tready;
      for (int i = 1; i <= NUM_ROUNDS; i++) vld[i] <= vld[i-1];
    end
  end

  // stage i holds state after inverse rounds down to key NUM_ROUNDS-i
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ rk[NUM_ROUNDS];
      for (int i = 1; i < NUM_ROUNDS; i++)
        st[i] <= inv_mix(inv_shift_sub(st[i-1]) ^ rk[NUM_ROUNDS-i]);
      st[NUM_ROUNDS] <= inv_shift_sub(st[NUM_ROUNDS-1]) ^ rk[0];
    end
  end

  assign m_axis_tvalid = vld[NUM_ROUNDS];
  assign m_axis_tdata  = {st[NUM_ROUNDS][63:0], st[NUM_ROUNDS][127:64]};

  `AES_ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "output lost under stall")
  `AES_ASSERT_IMPL(a_ready, clk, rst, !m_axis_tvalid && key_wait == 4'd0, s_axis_tready,
    "input blocked with empty output")
  `AES_ASSERT_IMPL(a_key_hold, clk, rst, key_wait != 4'd0, !s_axis_tready,
    "input taken while round keys settle")
  `AES_ASSERT_NEXT(a_flow, clk, rst, s_axis_tvalid && s_axis_tready, vld[0],
    "accepted word not in stage 0")

endmodule
